>>> design/fpa_pkg.sv
// Shared types, constants and helper functions for the Q24.8 fixed-point ALU.
// Used by every module of the block; depends on nothing else.
package fpa_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 8;
  localparam int QBITS     = WORD_BITS + FRAC_BITS;
  localparam int PROD_BITS = 2 * WORD_BITS;
  localparam int CMD_BITS  = 4;
  localparam int FLAG_BITS = 5;

  localparam logic [CMD_BITS-1:0] CMD_ADD      = 4'd0;
  localparam logic [CMD_BITS-1:0] CMD_SUB      = 4'd1;
  localparam logic [CMD_BITS-1:0] CMD_MUL      = 4'd2;
  localparam logic [CMD_BITS-1:0] CMD_DIV      = 4'd3;
  localparam logic [CMD_BITS-1:0] CMD_MIN      = 4'd4;
  localparam logic [CMD_BITS-1:0] CMD_MAX      = 4'd5;
  localparam logic [CMD_BITS-1:0] CMD_INC      = 4'd6;
  localparam logic [CMD_BITS-1:0] CMD_DEC      = 4'd7;
  localparam logic [CMD_BITS-1:0] CMD_TO_INT   = 4'd8;
  localparam logic [CMD_BITS-1:0] CMD_FROM_INT = 4'd9;

  localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  typedef enum logic [2:0] {
    OP_FAST = 3'b001,
    OP_MUL  = 3'b010,
    OP_DIV  = 3'b100
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic                 neg;
    logic [WORD_BITS-1:0] a_mag;
    logic [WORD_BITS-1:0] b_mag;
    logic [WORD_BITS-1:0] res;
    logic                 ov;
    logic                 dz;
    logic                 lt;
    logic                 eq;
    logic                 gt;
  } item_t;

  // Saturates a value one bit wider than the word; the top bit is overflow.
  function automatic logic [WORD_BITS:0] sat_wide(logic [WORD_BITS:0] v);
    logic [WORD_BITS:0] r;
    if (v[WORD_BITS] != v[WORD_BITS-1]) begin
      r = {1'b1, (v[WORD_BITS] ? WORD_MIN : WORD_MAX)};
    end else begin
      r = {1'b0, v[WORD_BITS-1:0]};
    end
    return r;
  endfunction

  // Applies a sign to a magnitude and saturates; the top bit is overflow.
  function automatic logic [WORD_BITS:0] finish(logic neg, logic [PROD_BITS-1:0] m);
    logic [PROD_BITS-1:0] lim;
    logic [PROD_BITS-1:0] v;
    logic                 ov;
    lim = {{(PROD_BITS-WORD_BITS){1'b0}}, WORD_MAX} + {{(PROD_BITS-1){1'b0}}, neg};
    ov  = m > lim;
    v   = ov ? lim : m;
    return {ov, (neg ? -v[WORD_BITS-1:0] : v[WORD_BITS-1:0])};
  endfunction

  function automatic logic [WORD_BITS-1:0] mag(logic [WORD_BITS-1:0] v);
    return v[WORD_BITS-1] ? -v : v;
  endfunction

endpackage

>>> design/fpa_front.sv
// Input register and decode: classifies each word, computes compare flags
// and the results of all operations but multiply and divide. Depends on fpa_pkg.
module fpa_front import fpa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CMD_BITS-1:0]  cmd,
  input  logic [WORD_BITS-1:0] operand_a,
  input  logic [WORD_BITS-1:0] operand_b,
  output logic                 out_valid,
  input  logic                 out_ready,
  output item_t                out_item
);

  logic                 vld;
  item_t                item;
  item_t                item_next;
  logic [WORD_BITS:0]   sat;
  logic [WORD_BITS:0]   ea;
  logic [WORD_BITS:0]   eb;
  logic [WORD_BITS:0]   one;
  logic [FRAC_BITS:0]   top_b;
  logic                 lt;

  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;
  assign out_item  = item;

  always_comb begin
    ea    = {operand_a[WORD_BITS-1], operand_a};
    eb    = {operand_b[WORD_BITS-1], operand_b};
    one   = {{WORD_BITS{1'b0}}, 1'b1};
    lt    = $signed(operand_a) < $signed(operand_b);
    top_b = operand_b[WORD_BITS-1:WORD_BITS-FRAC_BITS-1];
    sat   = '0;
    item_next       = '0;
    item_next.op    = OP_FAST;
    item_next.neg   = operand_a[WORD_BITS-1] ^ operand_b[WORD_BITS-1];
    item_next.a_mag = mag(operand_a);
    item_next.b_mag = mag(operand_b);
    item_next.lt    = lt;
    item_next.eq    = operand_a == operand_b;
    item_next.gt    = !lt && (operand_a != operand_b);
    case (cmd)
      CMD_ADD: begin
        sat = sat_wide(ea + eb);
      end
      CMD_SUB: begin
        sat = sat_wide(ea - eb);
      end
      CMD_MUL: begin
        item_next.op = OP_MUL;
      end
      CMD_DIV: begin
        item_next.op = OP_DIV;
        item_next.dz = operand_b == '0;
      end
      CMD_MIN: begin
        sat = {1'b0, (lt ? operand_a : operand_b)};
      end
      CMD_MAX: begin
        sat = {1'b0, (lt ? operand_b : operand_a)};
      end
      CMD_INC: begin
        sat = sat_wide(ea + one);
      end
      CMD_DEC: begin
        sat = sat_wide(ea - one);
      end
      CMD_TO_INT: begin
        sat = {1'b0, WORD_BITS'($signed(operand_a) >>> FRAC_BITS)};
      end
      CMD_FROM_INT: begin
        if (top_b == '0 || top_b == '1) begin
          sat = {1'b0, WORD_BITS'(operand_b << FRAC_BITS)};
        end else begin
          sat = {1'b1, (operand_b[WORD_BITS-1] ? WORD_MIN : WORD_MAX)};
        end
      end
      default: begin
        sat = '0;
      end
    endcase
    item_next.ov  = sat[WORD_BITS];
    item_next.res = sat[WORD_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= item_next;
    end
  end

endmodule

>>> design/fpa_queue.sv
// Two-entry queue between the decode front and the arithmetic back end.
// Depends on fpa_pkg.
module fpa_queue import fpa_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  not_empty,
  output item_t pop_item
);

  item_t       mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign full      = count == 2'd2;
  assign not_empty = count != 2'd0;
  assign pop_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

>>> design/fpa_back.sv
// Arithmetic back end: registered multiplier, one-bit-per-stage divider,
// rounding, saturation and the output register. Depends on fpa_pkg.
module fpa_back import fpa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_pop,
  input  item_t                 in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [WORD_BITS-1:0]  result,
  output logic [FLAG_BITS-1:0]  flags
);

  logic                 en;
  logic                 v    [QBITS+1];
  item_t                it   [QBITS+1];
  logic [WORD_BITS-1:0] rem  [QBITS+1];
  logic [QBITS-1:0]     num  [QBITS+1];
  logic [PROD_BITS-1:0] prod [QBITS+1];
  logic [WORD_BITS:0]   fin;
  logic [PROD_BITS-1:0] mul_q;
  logic [PROD_BITS-1:0] div_q;
  logic                 rnd_up;
  item_t                last;

  assign en     = !out_valid || out_ready;
  assign in_pop = en && in_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it[0]   <= in_item;
      rem[0]  <= '0;
      num[0]  <= {in_item.a_mag, {FRAC_BITS{1'b0}}};
      prod[0] <= PROD_BITS'(in_item.a_mag) * PROD_BITS'(in_item.b_mag);
    end
  end

  for (genvar k = 1; k <= QBITS; k++) begin : g_step
    logic [WORD_BITS:0] trial;
    logic               ge;
    assign trial = {rem[k-1], num[k-1][QBITS-1]};
    assign ge    = trial >= {1'b0, it[k-1].b_mag};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= v[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        it[k]   <= it[k-1];
        prod[k] <= prod[k-1];
        rem[k]  <= ge ? WORD_BITS'(trial - {1'b0, it[k-1].b_mag})
                      : trial[WORD_BITS-1:0];
        num[k]  <= {num[k-1][QBITS-2:0], ge};
      end
    end
  end

  always_comb begin
    last   = it[QBITS];
    mul_q  = (prod[QBITS] + (PROD_BITS'(1) << FRAC_BITS >> 1)) >> FRAC_BITS;
    rnd_up = {rem[QBITS], 1'b0} >= {1'b0, last.b_mag};
    div_q  = PROD_BITS'(num[QBITS]) + PROD_BITS'(rnd_up);
    fin    = {last.ov, last.res};
    case (last.op)
      OP_MUL: fin = finish(last.neg, mul_q);
      OP_DIV: fin = last.dz ? '0 : finish(last.neg, div_q);
      default: fin = {last.ov, last.res};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v[QBITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result <= fin[WORD_BITS-1:0];
      flags  <= {last.dz, fin[WORD_BITS], last.gt, last.eq, last.lt};
    end
  end

endmodule

>>> design/fixed_point_q24_8_alu.sv
// Channel  Direction  tdata                         tuser
// s_*      in         [31:0] operand_a, [63:32] b   [3:0] cmd
// m_*      out        [31:0] result                 lt, eq, gt, overflow, div_by_zero
// One word per cycle in and out while the output is not stalled; every word passes
// through the 40-stage restoring divider to keep order.
// Synchronous reset clears valid bits and queue pointers; data registers are not reset.
// An output stall freezes the back end; the front takes words until the queue fills.
// Top level of the Q24.8 ALU; depends on fpa_pkg, fpa_front, fpa_queue, fpa_back.
module fixed_point_q24_8_alu import fpa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [63:0]          s_tdata,  // operand_a, operand_b
  input  logic [CMD_BITS-1:0]  s_tuser,  // cmd
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [WORD_BITS-1:0] m_tdata,  // result
  output logic [FLAG_BITS-1:0] m_tuser   // less, equal, greater, overflow, div_by_zero
);

  logic  f_valid;
  logic  q_full;
  logic  q_pop;
  logic  q_not_empty;
  item_t f_item;
  item_t q_item;

  fpa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .cmd       (s_tuser),
    .operand_a (s_tdata[WORD_BITS-1:0]),
    .operand_b (s_tdata[2*WORD_BITS-1:WORD_BITS]),
    .out_valid (f_valid),
    .out_ready (!q_full),
    .out_item  (f_item)
  );

  fpa_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_valid && !q_full),
    .push_item (f_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_item  (q_item)
  );

  fpa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_not_empty),
    .in_pop    (q_pop),
    .in_item   (q_item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .result    (m_tdata),
    .flags     (m_tuser)
  );

  a_cmp_onehot: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot(m_tuser[2:0]))
    else $error("compare flags not one-hot");

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[4] |-> m_tdata == '0 && !m_tuser[3])
    else $error("divide by zero word carries data or overflow");

  a_dz_needs_zero_b: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[4] |-> !m_tuser[1] || m_tdata == '0)
    else $error("divide by zero flag inconsistent");

endmodule
